>>> design/assert_macros.svh
// Assertion macros shared by the task tick scheduler RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition never holds outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

>>> design/tts_pkg.sv
// Package for the task tick scheduler: field widths, command, status and mode codes.
// No dependencies; used by the interfaces, the top-level RTL module and the testbench.
`default_nettype none

package tts_pkg;

	localparam int unsigned CMD_W    = 2;
	localparam int unsigned ID_W     = 8;
	localparam int unsigned PERIOD_W = 32;
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned SLOT_W   = 6;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 2'd0,
		CMD_CREATE = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_OFF     = 2'd1,
		ST_BUSY    = 2'd2,
		ST_UNKNOWN = 2'd3
	} status_t;

	localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ONESHOT  = 2'd1;

endpackage

`default_nettype wire

>>> design/tts_if.sv
// Channel interfaces of the task tick scheduler: command requests, results and enable writes.
// Depends on tts_pkg for the field widths.
`default_nettype none

interface tts_req_if;
	logic                          valid;
	logic                          ready;
	logic [tts_pkg::CMD_W-1:0]     cmd;
	logic [tts_pkg::ID_W-1:0]      slot_id;
	logic [tts_pkg::PERIOD_W-1:0]  period;
	logic [tts_pkg::MODE_W-1:0]    mode;

	modport source (output valid, cmd, slot_id, period, mode, input ready);
	modport sink (input valid, cmd, slot_id, period, mode, output ready);
endinterface

interface tts_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [tts_pkg::STATUS_W-1:0]  status;
	logic                          fired;
	logic [tts_pkg::SLOT_W-1:0]    fired_slot;
	logic                          last;

	modport source (output valid, status, fired, fired_slot, last, input ready);
	modport sink (input valid, status, fired, fired_slot, last, output ready);
endinterface

interface tts_cfg_if;
	logic valid;
	logic ready;
	logic enable;

	modport source (output valid, enable, input ready);
	modport sink (input valid, enable, output ready);
endinterface

`default_nettype wire

>>> design/tts_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module tts_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  wr_en,
	input  wire logic [AW-1:0]         wr_addr,
	input  wire logic [WIDTH-1:0]      wr_data,
	input  wire logic [AW-1:0]         rd_addr,
	output logic      [WIDTH-1:0]      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

>>> design/task_tick_scheduler_table_top.sv
// Top level of the task tick scheduler: slot flags, sequencer and result register.
// Depends on tts_pkg, the channel interfaces in tts_if.sv, tts_ram and assert_macros.svh.
//
//  Channel   Direction  Carries
//  task_req  in         cmd, slot_id, period, mode (one request)
//  task_rsp  out        status, fired, fired_slot, last (one result)
//  cfg       in         enable (write data of the single register)
//
// A create, delete, ignored command or disabled tick passes through the accepting cycle
// and then S_RESP, which loads its result once the result register is free.
// An enabled tick passes through the accepting cycle, a walk of one slot a cycle through
// the count RAM's read-modify-write, and S_FIN, which loads the final result; from
// the second firing on, a firing waits on the result register, so a stalled result consumer
// stretches the walk.
// Reset clears the enable, the active and created flags and the sequencer at once; the
// RAMs are not cleared, since a slot's entries are written by create before they are used.
`default_nettype none

module task_tick_scheduler_table_top #(
	parameter int unsigned NUM_SLOTS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tts_req_if.sink    task_req,
	tts_rsp_if.source  task_rsp,
	tts_cfg_if.sink    cfg
);

	localparam int unsigned IW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int unsigned PW     = tts_pkg::PERIOD_W;
	localparam int unsigned MW     = tts_pkg::MODE_W;
	localparam int unsigned SLOT_W = tts_pkg::SLOT_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RESP,
		S_WALK,
		S_FIN
	} state_t;

	state_t                  state_q;
	logic                    enable_q;
	logic [NUM_SLOTS-1:0]    active_q;
	logic [NUM_SLOTS-1:0]    created_q;
	logic [IW-1:0]           idx_q;
	logic                    pend_valid_q;
	logic [IW-1:0]           pend_slot_q;
	tts_pkg::status_t        resp_q;

	logic                    out_valid_q;
	tts_pkg::status_t        out_status_q;
	logic                    out_fired_q;
	logic [SLOT_W-1:0]       out_slot_q;
	logic                    out_last_q;

	logic                    in_fire;
	logic                    out_free;
	logic                    id_in_range;
	logic [IW-1:0]           id_idx;
	tts_pkg::status_t        resp_d;
	logic                    create_ok;
	logic                    delete_ok;

	logic [PW-1:0]           cnt_rd;
	logic [PW-1:0]           cnt_cur;
	logic [PW-1:0]           cnt_inc;
	logic [MW+PW-1:0]        slot_rd;
	logic [PW-1:0]           period_rd;
	logic [MW-1:0]           mode_rd;
	logic                    fire;
	logic                    walk_hold;
	logic                    walk_step;
	logic                    walk_last;

	logic [IW-1:0]           rd_addr;
	logic                    cnt_we;
	logic [IW-1:0]           cnt_waddr;
	logic [PW-1:0]           cnt_wdata;

	logic                    out_load;
	tts_pkg::status_t        out_status_d;
	logic                    out_fired_d;
	logic [SLOT_W-1:0]       out_slot_d;
	logic                    out_last_d;

	// Period and mode of each slot, written by create only.
	tts_ram #(
		.WIDTH (MW + PW),
		.DEPTH (NUM_SLOTS)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (create_ok),
		.wr_addr (id_idx),
		.wr_data ({task_req.mode, task_req.period}),
		.rd_addr (rd_addr),
		.rd_data (slot_rd)
	);

	// Running tick count of each slot.
	tts_ram #(
		.WIDTH (PW),
		.DEPTH (NUM_SLOTS)
	) u_count_ram (
		.clk     (clk),
		.wr_en   (cnt_we),
		.wr_addr (cnt_waddr),
		.wr_data (cnt_wdata),
		.rd_addr (rd_addr),
		.rd_data (cnt_rd)
	);

	// Handshake outputs.
	assign task_req.ready      = (state_q == S_IDLE);
	assign cfg.ready           = 1'b1;
	assign task_rsp.valid      = out_valid_q;
	assign task_rsp.status     = out_status_q;
	assign task_rsp.fired      = out_fired_q;
	assign task_rsp.fired_slot = out_slot_q;
	assign task_rsp.last       = out_last_q;

	assign in_fire  = task_req.valid && task_req.ready;
	assign out_free = !out_valid_q || task_rsp.ready;

	// Decode of a create or delete request against the slot flags.
	always_comb begin
		id_in_range = (task_req.slot_id < tts_pkg::ID_W'(NUM_SLOTS));
		id_idx      = task_req.slot_id[IW-1:0];
		create_ok   = 1'b0;
		delete_ok   = 1'b0;
		resp_d      = tts_pkg::ST_OK;
		unique case (task_req.cmd)
			tts_pkg::CMD_CREATE: begin
				if (!enable_q) begin
					resp_d = tts_pkg::ST_OFF;
				end else if (id_in_range && !active_q[id_idx]) begin
					create_ok = in_fire;
				end else begin
					resp_d = tts_pkg::ST_BUSY;
				end
			end
			tts_pkg::CMD_DELETE: begin
				if (task_req.slot_id == '0 || (id_in_range && created_q[id_idx])) begin
					delete_ok = in_fire;
				end else begin
					resp_d = tts_pkg::ST_UNKNOWN;
				end
			end
			tts_pkg::CMD_TICK: begin
				if (!enable_q) begin
					resp_d = tts_pkg::ST_OFF;
				end
			end
			default: begin
				resp_d = tts_pkg::ST_OK;
			end
		endcase
	end

	// Evaluation of the slot under the walk index; a slot never created counts from zero.
	always_comb begin
		period_rd = slot_rd[PW-1:0];
		mode_rd   = slot_rd[MW+PW-1:PW];
		cnt_cur   = created_q[idx_q] ? cnt_rd : '0;
		cnt_inc   = cnt_cur + PW'(1);
		fire      = active_q[idx_q] && (cnt_inc == period_rd) &&
			(mode_rd == tts_pkg::MODE_PERIODIC || mode_rd == tts_pkg::MODE_ONESHOT);
		walk_hold = (state_q == S_WALK) && fire && pend_valid_q && !out_free;
		walk_step = (state_q == S_WALK) && !walk_hold;
		walk_last = (idx_q == LAST_IDX);
	end

	// RAM address and count write selection.
	always_comb begin
		rd_addr   = idx_q;
		cnt_we    = 1'b0;
		cnt_waddr = idx_q;
		cnt_wdata = fire ? '0 : cnt_inc;
		if (in_fire) begin
			rd_addr = '0;
		end else if (walk_step && !walk_last) begin
			rd_addr = idx_q + IW'(1);
		end
		if (create_ok) begin
			cnt_we    = 1'b1;
			cnt_waddr = id_idx;
			cnt_wdata = '0;
		end else if (walk_step) begin
			cnt_we = 1'b1;
		end
	end

	// Result selection: a firing is held back until the next one or the finish, so that the final one carries last.
	always_comb begin
		out_load     = 1'b0;
		out_status_d = tts_pkg::ST_OK;
		out_fired_d  = 1'b0;
		out_slot_d   = '0;
		out_last_d   = 1'b1;
		unique case (state_q)
			S_RESP: begin
				out_load     = out_free;
				out_status_d = resp_q;
			end
			S_WALK: begin
				out_load    = walk_step && fire && pend_valid_q;
				out_fired_d = 1'b1;
				out_slot_d  = SLOT_W'(pend_slot_q);
				out_last_d  = 1'b0;
			end
			S_FIN: begin
				out_load    = out_free;
				out_fired_d = pend_valid_q;
				out_slot_d  = pend_valid_q ? SLOT_W'(pend_slot_q) : '0;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// Sequencer, slot flags, enable register and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			enable_q     <= 1'b0;
			active_q     <= '0;
			created_q    <= '0;
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				enable_q <= cfg.enable;
			end

			if (out_load) begin
				out_valid_q  <= 1'b1;
				out_status_q <= out_status_d;
				out_fired_q  <= out_fired_d;
				out_slot_q   <= out_slot_d;
				out_last_q   <= out_last_d;
			end else if (task_rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						resp_q <= resp_d;
						if (create_ok) begin
							active_q[id_idx]  <= 1'b1;
							created_q[id_idx] <= 1'b1;
						end
						if (delete_ok) begin
							active_q[id_idx] <= 1'b0;
						end
						idx_q <= '0;
						if (task_req.cmd == tts_pkg::CMD_TICK && enable_q) begin
							state_q <= S_WALK;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_WALK: begin
					if (walk_step) begin
						if (fire) begin
							pend_valid_q <= 1'b1;
							pend_slot_q  <= idx_q;
							if (mode_rd == tts_pkg::MODE_ONESHOT) begin
								active_q[idx_q] <= 1'b0;
							end
						end
						if (walk_last) begin
							state_q <= S_FIN;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`include "assert_macros.svh"

	// The walk index stays inside the table.
	`ASSERT_CLK(a_walk_idx_range, (state_q == S_WALK) |-> (idx_q <= LAST_IDX), "walk index out of range")
	// No firing is left pending once the sequencer is idle.
	`ASSERT_NEVER(a_idle_no_pend, (state_q == S_IDLE) && pend_valid_q, "pending firing left in idle")
	// A final result is loaded only when a request finishes.
	`ASSERT_CLK(a_last_at_end, (out_load && out_last_d) |-> (state_q == S_RESP || state_q == S_FIN), "final result loaded mid-walk")
	// A held firing never overwrites a result that is still waiting.
	`ASSERT_NEVER(a_no_overwrite, out_load && out_valid_q && !task_rsp.ready, "result overwritten")

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Testbench for task_tick_scheduler_table_top: directed and random command requests against
// a slot-table scoreboard that predicts every result. Depends on tts_pkg and the channel
// interfaces in tts_if.sv, and on the RTL of the scheduler.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SLOT_COUNT = 16;
	localparam int unsigned RUN_LIMIT  = 200000;
	localparam int unsigned MAX_SHOWN  = 10;

	// Modes that are stored and counted but never fire.
	localparam logic [tts_pkg::MODE_W-1:0] MODE_DORMANT    = 2'd2;
	localparam logic [tts_pkg::MODE_W-1:0] MODE_DORMANT_HI = 2'd3;

	typedef struct {
		tts_pkg::cmd_t                cmd;
		logic [tts_pkg::ID_W-1:0]     slot_id;
		logic [tts_pkg::PERIOD_W-1:0] period;
		logic [tts_pkg::MODE_W-1:0]   mode;
	} sched_req_t;

	typedef struct {
		tts_pkg::status_t           status;
		logic                       fired;
		logic [tts_pkg::SLOT_W-1:0] fired_slot;
		logic                       last;
	} sched_result_t;

	// Shadow copy of the slot table and the queue of results it says are due.
	class tick_scoreboard;
		bit                           enabled;
		bit                           active[SLOT_COUNT];
		bit                           created[SLOT_COUNT];
		bit [tts_pkg::PERIOD_W-1:0]   period_of[SLOT_COUNT];
		bit [tts_pkg::PERIOD_W-1:0]   ticks[SLOT_COUNT];
		bit [tts_pkg::MODE_W-1:0]     mode_of[SLOT_COUNT];
		sched_result_t                due_results[$];
		int unsigned                  mismatches;

		function void set_enable(bit on);
			enabled = on;
		endfunction

		function void push_result(tts_pkg::status_t s, bit f, int unsigned slot, bit l);
			sched_result_t r;
			r.status = s;
			r.fired = f;
			r.fired_slot = tts_pkg::SLOT_W'(slot);
			r.last = l;
			due_results.push_back(r);
		endfunction

		// Update the table for one accepted request and queue the results it causes.
		function void apply_request(sched_req_t req);
			bit               hit[SLOT_COUNT];
			int unsigned      fires;
			int unsigned      seen;
			tts_pkg::status_t st;
			fires = 0;
			seen = 0;
			case (req.cmd)
				tts_pkg::CMD_TICK: begin
					if (!enabled) begin
						push_result(tts_pkg::ST_OFF, 1'b0, 0, 1'b1);
					end else begin
						for (int unsigned i = 0; i < SLOT_COUNT; i++) begin
							ticks[i] = ticks[i] + 1;
							hit[i] = active[i] && ticks[i] == period_of[i] &&
								(mode_of[i] == tts_pkg::MODE_PERIODIC ||
								mode_of[i] == tts_pkg::MODE_ONESHOT);
							if (hit[i]) begin
								fires++;
								ticks[i] = '0;
								if (mode_of[i] == tts_pkg::MODE_ONESHOT) begin
									mode_of[i] = tts_pkg::MODE_PERIODIC;
									active[i] = 1'b0;
								end
							end
						end
						if (fires == 0) begin
							push_result(tts_pkg::ST_OK, 1'b0, 0, 1'b1);
						end
						for (int unsigned i = 0; i < SLOT_COUNT; i++) begin
							if (hit[i]) begin
								seen++;
								push_result(tts_pkg::ST_OK, 1'b1, i, seen == fires);
							end
						end
					end
				end
				tts_pkg::CMD_CREATE: begin
					if (!enabled) begin
						st = tts_pkg::ST_OFF;
					end else if (req.slot_id < SLOT_COUNT && !active[req.slot_id]) begin
						st = tts_pkg::ST_OK;
						active[req.slot_id] = 1'b1;
						created[req.slot_id] = 1'b1;
						period_of[req.slot_id] = req.period;
						ticks[req.slot_id] = '0;
						mode_of[req.slot_id] = req.mode;
					end else begin
						st = tts_pkg::ST_BUSY;
					end
					push_result(st, 1'b0, 0, 1'b1);
				end
				tts_pkg::CMD_DELETE: begin
					// Slot zero always deletes; other ids need a past create.
					st = tts_pkg::ST_UNKNOWN;
					if (req.slot_id == 0) begin
						active[0] = 1'b0;
						st = tts_pkg::ST_OK;
					end else if (req.slot_id < SLOT_COUNT && created[req.slot_id]) begin
						active[req.slot_id] = 1'b0;
						st = tts_pkg::ST_OK;
					end
					push_result(st, 1'b0, 0, 1'b1);
				end
				default: begin
					push_result(tts_pkg::ST_OK, 1'b0, 0, 1'b1);
				end
			endcase
		endfunction

		function void report(string what, sched_result_t exp_r, sched_result_t got);
			mismatches++;
			if (mismatches <= MAX_SHOWN) begin
				$display("%0t: %s: expected status=%0d fired=%0d slot=%0d last=%0d,",
					$realtime, what, exp_r.status, exp_r.fired, exp_r.fired_slot,
					exp_r.last);
				$display("    got status=%0d fired=%0d slot=%0d last=%0d",
					got.status, got.fired, got.fired_slot, got.last);
			end
		endfunction

		// Compare one accepted result with the oldest one due.
		function void check_result(sched_result_t got);
			sched_result_t exp_r;
			if (due_results.size() == 0) begin
				exp_r = got;
				report("result with nothing due", exp_r, got);
			end else begin
				exp_r = due_results.pop_front();
				if (got.status != exp_r.status || got.fired != exp_r.fired ||
						got.fired_slot != exp_r.fired_slot || got.last != exp_r.last) begin
					report("result mismatch", exp_r, got);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   quiet;
	int unsigned cycle_count;

	tick_scoreboard sb = new;

	tts_req_if task_req();
	tts_rsp_if task_rsp();
	tts_cfg_if cfg();

	task_tick_scheduler_table_top #(
		.NUM_SLOTS(SLOT_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.task_req(task_req),
		.task_rsp(task_rsp),
		.cfg(cfg)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Random gaps on either side, suppressed during the quiet stretch.
	function automatic bit take_break();
		return !quiet && $urandom_range(99) < 12;
	endfunction

	function automatic sched_req_t mk_req(tts_pkg::cmd_t c, logic [tts_pkg::ID_W-1:0] id,
			logic [tts_pkg::PERIOD_W-1:0] p, logic [tts_pkg::MODE_W-1:0] m);
		sched_req_t r;
		r.cmd = c;
		r.slot_id = id;
		r.period = p;
		r.mode = m;
		return r;
	endfunction

	// Mostly in-range slots and short periods so that slots fire often.
	function automatic sched_req_t random_request();
		sched_req_t  r;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 42) begin
			r.cmd = tts_pkg::CMD_TICK;
		end else if (pick < 72) begin
			r.cmd = tts_pkg::CMD_CREATE;
		end else if (pick < 93) begin
			r.cmd = tts_pkg::CMD_DELETE;
		end else begin
			r.cmd = tts_pkg::CMD_NOP;
		end
		r.slot_id = ($urandom_range(99) < 85)
			? tts_pkg::ID_W'($urandom_range(SLOT_COUNT - 1))
			: tts_pkg::ID_W'($urandom_range(255));
		pick = $urandom_range(99);
		if (pick < 70) begin
			r.period = $urandom_range(6, 1);
		end else if (pick < 85) begin
			r.period = $urandom_range(40, 7);
		end else if (pick < 95) begin
			r.period = $urandom();
		end else begin
			r.period = '0;
		end
		pick = $urandom_range(99);
		if (pick < 45) begin
			r.mode = tts_pkg::MODE_PERIODIC;
		end else if (pick < 85) begin
			r.mode = tts_pkg::MODE_ONESHOT;
		end else begin
			r.mode = ($urandom_range(1) != 0) ? MODE_DORMANT : MODE_DORMANT_HI;
		end
		return r;
	endfunction

	// Present one request at the falling edge and hold it until accepted.
	task automatic send_request(sched_req_t r);
		@(negedge clk);
		while (take_break()) begin
			task_req.valid <= 1'b0;
			@(negedge clk);
		end
		task_req.valid <= 1'b1;
		task_req.cmd <= r.cmd;
		task_req.slot_id <= r.slot_id;
		task_req.period <= r.period;
		task_req.mode <= r.mode;
		@(posedge clk);
		while (!task_req.ready) @(posedge clk);
		sb.apply_request(r);
	endtask

	task automatic stop_requests();
		@(negedge clk);
		task_req.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.due_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_enable(bit on);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.enable <= on;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		sb.set_enable(on);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Clear the whole table and refill every slot with the same period, so that
	// a tick can fire all of them at once.
	task automatic fill_table(logic [tts_pkg::PERIOD_W-1:0] p);
		for (int unsigned i = 0; i < SLOT_COUNT; i++) begin
			send_request(mk_req(tts_pkg::CMD_DELETE, tts_pkg::ID_W'(i), '0,
				tts_pkg::MODE_PERIODIC));
		end
		for (int unsigned i = 0; i < SLOT_COUNT; i++) begin
			send_request(mk_req(tts_pkg::CMD_CREATE, tts_pkg::ID_W'(i), p,
				($urandom_range(1) != 0) ? tts_pkg::MODE_ONESHOT : tts_pkg::MODE_PERIODIC));
		end
	endtask

	task automatic run_random(int unsigned count);
		for (int unsigned k = 0; k < count; k++) begin
			quiet = (k >= 40 && k < 100);
			send_request(random_request());
		end
		quiet = 1'b0;
	endtask

	// Result side: random back-pressure, sampled at the rising edge.
	initial begin
		task_rsp.ready <= 1'b0;
		forever begin
			sched_result_t got;
			@(negedge clk);
			task_rsp.ready <= !take_break();
			@(posedge clk);
			if (arst_n && task_rsp.valid && task_rsp.ready) begin
				got.status = tts_pkg::status_t'(task_rsp.status);
				got.fired = task_rsp.fired;
				got.fired_slot = task_rsp.fired_slot;
				got.last = task_rsp.last;
				sb.check_result(got);
			end
		end
	end

	// Watchdog on the total run length.
	initial begin
		cycle_count = 0;
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("== FAIL ==");
		$finish;
	end

	// Main sequence: reset, directed requests, then random phases.
	initial begin
		quiet = 1'b0;
		arst_n <= 1'b0;
		task_req.valid <= 1'b0;
		task_req.cmd <= tts_pkg::CMD_NOP;
		task_req.slot_id <= '0;
		task_req.period <= '0;
		task_req.mode <= tts_pkg::MODE_PERIODIC;
		cfg.valid <= 1'b0;
		cfg.enable <= 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Disabled after reset: ticks and creates refused, deletes still work.
		send_request(mk_req(tts_pkg::CMD_TICK, 8'd0, 32'd0, tts_pkg::MODE_PERIODIC));
		send_request(mk_req(tts_pkg::CMD_CREATE, 8'd4, 32'd5, tts_pkg::MODE_PERIODIC));
		send_request(mk_req(tts_pkg::CMD_DELETE, 8'd0, 32'd0, tts_pkg::MODE_PERIODIC));
		send_request(mk_req(tts_pkg::CMD_DELETE, 8'd5, 32'd0, tts_pkg::MODE_PERIODIC));
		send_request(mk_req(tts_pkg::CMD_DELETE, 8'd255, 32'hFFFF_FFFF, MODE_DORMANT_HI));
		send_request(mk_req(tts_pkg::CMD_NOP, 8'd0, 32'd0, tts_pkg::MODE_PERIODIC));
		stop_requests();
		wait_drained();
		write_enable(1'b1);

		// Every mode, busy and out-of-range creates, period extremes.
		send_request(mk_req(tts_pkg::CMD_CREATE, 8'd0, 32'd1, tts_pkg::MODE_PERIODIC));
		send_request(mk_req(tts_pkg::CMD_CREATE, 8'd15, 32'd2, tts_pkg::MODE_ONESHOT));
		send_request(mk_req(tts_pkg::CMD_CREATE, 8'd3, 32'd1, MODE_DORMANT));
		send_request(mk_req(tts_pkg::CMD_CREATE, 8'd7, 32'd1, MODE_DORMANT_HI));
		send_request(mk_req(tts_pkg::CMD_CREATE, 8'd3, 32'd4, tts_pkg::MODE_PERIODIC));
		send_request(mk_req(tts_pkg::CMD_CREATE, 8'd16, 32'd1, tts_pkg::MODE_PERIODIC));
		send_request(mk_req(tts_pkg::CMD_CREATE, 8'd255, 32'hFFFF_FFFF, MODE_DORMANT_HI));
		send_request(mk_req(tts_pkg::CMD_CREATE, 8'd1, 32'd0, tts_pkg::MODE_PERIODIC));
		send_request(mk_req(tts_pkg::CMD_CREATE, 8'd2, 32'hFFFF_FFFF, tts_pkg::MODE_ONESHOT));
		send_request(mk_req(tts_pkg::CMD_TICK, 8'd0, 32'd0, tts_pkg::MODE_PERIODIC));
		send_request(mk_req(tts_pkg::CMD_TICK, 8'd255, 32'hFFFF_FFFF, MODE_DORMANT_HI));
		send_request(mk_req(tts_pkg::CMD_TICK, 8'd0, 32'd0, tts_pkg::MODE_PERIODIC));
		// Delete of a one-shot slot that already fired, then of slot zero and unknown ids.
		send_request(mk_req(tts_pkg::CMD_DELETE, 8'd15, 32'd0, tts_pkg::MODE_PERIODIC));
		send_request(mk_req(tts_pkg::CMD_DELETE, 8'd0, 32'd0, tts_pkg::MODE_PERIODIC));
		send_request(mk_req(tts_pkg::CMD_DELETE, 8'd200, 32'd0, tts_pkg::MODE_PERIODIC));
		send_request(mk_req(tts_pkg::CMD_DELETE, 8'd9, 32'd0, tts_pkg::MODE_PERIODIC));
		send_request(mk_req(tts_pkg::CMD_NOP, 8'd255, 32'hFFFF_FFFF, MODE_DORMANT_HI));
		send_request(mk_req(tts_pkg::CMD_TICK, 8'd0, 32'd0, tts_pkg::MODE_PERIODIC));

		// Enabled random phase, starting from a table where every slot fires together.
		fill_table(32'd1);
		send_request(mk_req(tts_pkg::CMD_TICK, 8'd0, 32'd0, tts_pkg::MODE_PERIODIC));
		run_random(90);
		stop_requests();
		wait_drained();

		// Disabled phase: ticks frozen, deletes still applied.
		write_enable(1'b0);
		run_random(30);
		stop_requests();
		wait_drained();

		// Enabled again with the table left as it was.
		write_enable(1'b1);
		run_random(60);
		fill_table(32'd3);
		run_random(60);
		stop_requests();
		wait_drained();
		repeat (SLOT_COUNT + 4) @(posedge clk);

		if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
